/* src/heap_indexed_block_allocator_top_macros.svh */
// Assertion macros shared by the allocator RTL.
// Expects signals clk and rst_n in the including scope.
`ifndef HEAP_INDEXED_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define HEAP_INDEXED_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define HIBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hiba assertion failed");

// next-cycle implication
`define HIBA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hiba assertion failed");

`endif

/* src/hiba_pkg.sv */
// Package for the heap indexed block allocator: sizes, codes, payload types.
// No dependencies.
package hiba_pkg;

    localparam int ARENA_BYTES  = 1048576;
    localparam int HEAP_DEPTH   = 1024;
    localparam int HEADER_BYTES = 32;

    localparam int SLOTS     = ARENA_BYTES / 8;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int HIDX_W    = $clog2(HEAP_DEPTH);
    localparam int CNT_W     = HIDX_W + 1;
    localparam int SIZE_W    = $clog2(ARENA_BYTES);
    localparam int OFF_W     = 20;
    localparam int REQ_W     = 21;
    localparam int ADJ_W     = REQ_W + 1;
    localparam int HDR_SLOTS = HEADER_BYTES / 8;
    localparam int INIT_SIZE = ARENA_BYTES - HEADER_BYTES;

    typedef enum logic [1:0] {
        K_ALLOC   = 2'd0,
        K_FREE    = 2'd1,
        K_REALLOC = 2'd2,
        K_RSVD    = 2'd3
    } hiba_kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_DFREE   = 3'd3,
        ST_FULL    = 3'd4
    } hiba_status_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] payload_offset;
    } hiba_in_t;

    typedef struct packed {
        logic [OFF_W-1:0] result_offset;
        logic [REQ_W-1:0] granted_bytes;
        logic             moved;
        logic [2:0]       status;
    } hiba_out_t;

    typedef struct packed {
        logic              valid;
        logic              is_free;
        logic              has_prev;
        logic              has_next;
        logic [SIZE_W-1:0] size;
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] next;
    } hiba_hdr_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] size;
    } hiba_ent_t;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_LK_RD, S_LK_CHK, S_A_START, S_SCAN_RD, S_SCAN_CHK,
        S_RM, S_RM_LAST, S_SU_RD, S_SU_CHK, S_SD_START, S_SD_GET, S_SD_CH,
        S_SD_L, S_SD_R, S_SD_END, S_INS, S_A_RD, S_A_CHK, S_A_NX_RD, S_A_NX_WR,
        S_A_WC, S_A_OK, S_F_RD, S_F_B, S_F_N, S_F_N2, S_F_NN_RD, S_F_NN_WR,
        S_F_P_CHK, S_F_P, S_F_P2, S_F_PN_RD, S_F_PN_WR, S_F_INS, S_DONE
    } hiba_state_t;

endpackage

/* src/hiba_ram.sv */
// Generic single-port RAM, one write or one read a cycle, registered read.
// No dependencies.
module hiba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

/* src/heap_indexed_block_allocator_top.sv */
// Heap indexed block allocator: header store, size-ordered free heap, sequencer.
// Depends on hiba_pkg, hiba_ram and the assertion macro header.
//
// Usage: present a command on cmd and raise start while busy is low; the
// transaction is taken at that edge. kind selects allocate, free or reallocate.
// busy stays high until the result is shown: done pulses for one cycle with
// result valid in that cycle. The receiver cannot stall; it must take it then.
// One command at a time. The work varies: an allocate scans the free heap
// entry by entry, then removes the chosen entry, sifts the heap and splits;
// a free runs up to two scans for neighbor merges, then an insert. A moving
// reallocate, which can run three full heap scans, takes longest. The single
// shared sequencer and the one port of each memory (header store, heap)
// set the pace.
// After reset the header store is swept one entry a cycle, all 131072
// entries with busy high, leaving one free block spanning the arena.
`include "heap_indexed_block_allocator_top_macros.svh"

module heap_indexed_block_allocator_top
    import hiba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  hiba_in_t  cmd,
    output logic      busy,
    output logic      done,
    output hiba_out_t result
);
    hiba_state_t state_reg, state_next, ret_reg, ret_next;

    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [1:0]        kind_reg, kind_next;
    logic [ADJ_W-1:0]  adj_reg, adj_next;
    logic [OFF_W-1:0]  pay_reg, pay_next;
    logic              fmode_reg, fmode_next;
    logic              mv_reg, mv_next;
    logic              fit_reg, fit_next;
    logic              rm_reg, rm_next;
    logic              split_reg, split_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  sel_idx_reg, sel_idx_next;
    logic [HIDX_W-1:0] rm_idx_reg, rm_idx_next;
    logic [SLOT_W-1:0] tgt_reg, tgt_next;
    logic [SLOT_W-1:0] bh_reg, bh_next;
    logic [SLOT_W-1:0] ah_reg, ah_next;
    logic [SLOT_W-1:0] nslot_reg, nslot_next;
    hiba_ent_t         ent_reg, ent_next;
    hiba_ent_t         sel_ent_reg, sel_ent_next;
    hiba_hdr_t         b_reg, b_next;
    hiba_hdr_t         nb_reg, nb_next;
    hiba_hdr_t         c_reg, c_next;
    logic [OFF_W-1:0]  roff_reg, roff_next;
    logic [SIZE_W-1:0] rsize_reg, rsize_next;
    logic              moved_reg, moved_next;
    hiba_status_t      status_reg, status_next;
    logic              drop_reg, drop_next;

    logic              hd_we;
    logic [SLOT_W-1:0] hd_addr;
    hiba_hdr_t         hd_wdata, hd_rdata;
    logic              hp_we;
    logic [HIDX_W-1:0] hp_addr;
    hiba_ent_t         hp_wdata, hp_rdata;

    hiba_ram #(.WIDTH($bits(hiba_hdr_t)), .DEPTH(SLOTS)) u_hdr_ram (
        .clk   (clk),
        .we    (hd_we),
        .addr  (hd_addr),
        .wdata (hd_wdata),
        .rdata (hd_rdata)
    );

    hiba_ram #(.WIDTH($bits(hiba_ent_t)), .DEPTH(HEAP_DEPTH)) u_heap_ram (
        .clk   (clk),
        .we    (hp_we),
        .addr  (hp_addr),
        .wdata (hp_wdata),
        .rdata (hp_rdata)
    );

    // decode of the incoming command
    logic              in_free_op, in_lk_bad, in_pay_zero;
    logic [SLOT_W-1:0] in_slot;
    logic [ADJ_W-1:0]  in_adj;
    // shared datapath terms
    logic              fits, scan_hit, lk_bad, keep_fits, split_ok, heap_full;
    logic [SLOT_W-1:0] n_slot;
    logic [SIZE_W-1:0] s_size;
    logic [CNT_W-1:0]  l_idx, r_idx, par_idx, cnt_dec;
    hiba_state_t       su_exit;
    hiba_hdr_t         init_hdr;

    assign in_pay_zero = (cmd.payload_offset == '0);
    assign in_free_op  = (cmd.kind == K_FREE) ||
                         (cmd.kind == K_REALLOC && !in_pay_zero && cmd.request_bytes == '0);
    assign in_lk_bad   = (cmd.payload_offset < OFF_W'(HEADER_BYTES)) ||
                         (cmd.payload_offset[2:0] != 3'd0);
    assign in_slot     = cmd.payload_offset[OFF_W-1:3] - SLOT_W'(HDR_SLOTS);
    assign in_adj      = (ADJ_W'(cmd.request_bytes) + ADJ_W'(7)) & ~ADJ_W'(7);

    assign fits      = ADJ_W'(hp_rdata.size) >= adj_reg;
    assign scan_hit  = fit_reg ? fits : (hp_rdata.slot == tgt_reg);
    assign lk_bad    = !hd_rdata.valid || hd_rdata.is_free;
    assign keep_fits = ADJ_W'(hd_rdata.size) >= adj_reg;
    assign split_ok  = ADJ_W'(hd_rdata.size) >= adj_reg + ADJ_W'(HEADER_BYTES + 8);
    assign n_slot    = ah_reg + SLOT_W'(HDR_SLOTS) + adj_reg[SLOT_W+2:3];
    assign s_size    = hd_rdata.size - adj_reg[SIZE_W-1:0] - SIZE_W'(HEADER_BYTES);
    assign l_idx     = {idx_reg[HIDX_W-1:0], 1'b1};
    assign r_idx     = l_idx + CNT_W'(1);
    assign par_idx   = (idx_reg - CNT_W'(1)) >> 1;
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign heap_full = cnt_reg >= CNT_W'(HEAP_DEPTH);
    assign su_exit   = rm_reg ? S_SD_START : ret_reg;

    always_comb
    begin
        init_hdr       = '0;
        init_hdr.valid = 1'b1;
        init_hdr.is_free = 1'b1;
        init_hdr.size  = SIZE_W'(INIT_SIZE);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_reg == SLOT_W'(SLOTS - 1)) state_next = S_IDLE;
            S_IDLE:
                if (start)
                begin
                    if (cmd.kind == K_ALLOC)
                        state_next = S_A_START;
                    else if (in_free_op || cmd.kind == K_REALLOC)
                    begin
                        if (in_pay_zero)
                            state_next = in_free_op ? S_DONE : S_A_START;
                        else if (in_lk_bad)
                            state_next = S_DONE;
                        else
                            state_next = S_LK_RD;
                    end
                    else
                        state_next = S_DONE;
                end
            S_LK_RD:    state_next = S_LK_CHK;
            S_LK_CHK:
                if (lk_bad)         state_next = S_DONE;
                else if (fmode_reg) state_next = S_F_RD;
                else if (keep_fits) state_next = S_DONE;
                else                state_next = S_A_START;
            S_A_START:  state_next = (adj_reg == '0) ? S_DONE : S_SCAN_RD;
            S_SCAN_RD:
                if (idx_reg >= cnt_reg) state_next = fit_reg ? S_DONE : ret_reg;
                else                    state_next = S_SCAN_CHK;
            S_SCAN_CHK: state_next = scan_hit ? S_RM : S_SCAN_RD;
            S_RM:       state_next = (idx_reg < cnt_dec) ? S_RM_LAST : ret_reg;
            S_RM_LAST:  state_next = S_SU_RD;
            S_SU_RD:    state_next = (idx_reg == '0) ? su_exit : S_SU_CHK;
            S_SU_CHK:   state_next = (hp_rdata.size > ent_reg.size) ? S_SU_RD : su_exit;
            S_SD_START: state_next = S_SD_GET;
            S_SD_GET:   state_next = S_SD_CH;
            S_SD_CH:    state_next = (l_idx < cnt_reg) ? S_SD_L : S_SD_END;
            S_SD_L:     state_next = (r_idx < cnt_reg) ? S_SD_R : S_SD_END;
            S_SD_R:     state_next = S_SD_END;
            S_SD_END:   state_next = (sel_idx_reg == idx_reg) ? ret_reg : S_SD_CH;
            S_INS:      state_next = heap_full ? ret_reg : S_SU_RD;
            S_A_RD:     state_next = S_A_CHK;
            S_A_CHK:    state_next = (split_ok && hd_rdata.has_next) ? S_A_NX_RD : S_A_WC;
            S_A_NX_RD:  state_next = S_A_NX_WR;
            S_A_NX_WR:  state_next = S_A_WC;
            S_A_WC:     state_next = split_reg ? S_INS : S_A_OK;
            S_A_OK:     state_next = mv_reg ? S_F_RD : S_DONE;
            S_F_RD:     state_next = S_F_B;
            S_F_B:      state_next = hd_rdata.has_next ? S_F_N : S_F_P_CHK;
            S_F_N:      state_next = hd_rdata.is_free ? S_SCAN_RD : S_F_P_CHK;
            S_F_N2:     state_next = nb_reg.has_next ? S_F_NN_RD : S_F_P_CHK;
            S_F_NN_RD:  state_next = S_F_NN_WR;
            S_F_NN_WR:  state_next = S_F_P_CHK;
            S_F_P_CHK:  state_next = b_reg.has_prev ? S_F_P : S_F_INS;
            S_F_P:      state_next = hd_rdata.is_free ? S_SCAN_RD : S_F_INS;
            S_F_P2:     state_next = b_reg.has_next ? S_F_PN_RD : S_F_INS;
            S_F_PN_RD:  state_next = S_F_PN_WR;
            S_F_PN_WR:  state_next = S_F_INS;
            S_F_INS:    state_next = S_INS;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // memory controls and datapath
    always_comb
    begin
        ret_next     = ret_reg;
        clr_next     = clr_reg;
        kind_next    = kind_reg;
        adj_next     = adj_reg;
        pay_next     = pay_reg;
        fmode_next   = fmode_reg;
        mv_next      = mv_reg;
        fit_next     = fit_reg;
        rm_next      = rm_reg;
        split_next   = split_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        sel_idx_next = sel_idx_reg;
        rm_idx_next  = rm_idx_reg;
        tgt_next     = tgt_reg;
        bh_next      = bh_reg;
        ah_next      = ah_reg;
        nslot_next   = nslot_reg;
        ent_next     = ent_reg;
        sel_ent_next = sel_ent_reg;
        b_next       = b_reg;
        nb_next      = nb_reg;
        c_next       = c_reg;
        roff_next    = roff_reg;
        rsize_next   = rsize_reg;
        moved_next   = moved_reg;
        status_next  = status_reg;
        drop_next    = drop_reg;

        hd_we    = 1'b0;
        hd_addr  = bh_reg;
        hd_wdata = b_reg;
        hp_we    = 1'b0;
        hp_addr  = idx_reg[HIDX_W-1:0];
        hp_wdata = ent_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                hd_we    = 1'b1;
                hd_addr  = clr_reg;
                hd_wdata = (clr_reg == '0) ? init_hdr : '0;
                hp_we    = (clr_reg == '0);
                hp_addr  = '0;
                hp_wdata = '{slot: '0, size: SIZE_W'(INIT_SIZE)};
                clr_next = clr_reg + SLOT_W'(1);
            end
            S_IDLE:
                if (start)
                begin
                    kind_next   = cmd.kind;
                    adj_next    = in_adj;
                    pay_next    = cmd.payload_offset;
                    bh_next     = in_slot;
                    fmode_next  = in_free_op;
                    mv_next     = 1'b0;
                    roff_next   = '0;
                    rsize_next  = '0;
                    moved_next  = 1'b0;
                    drop_next   = 1'b0;
                    status_next = ((in_free_op || cmd.kind == K_REALLOC) && !in_pay_zero
                                   && in_lk_bad) ? ST_DFREE : ST_NULL;
                end
            S_LK_RD:
                hd_addr = bh_reg;
            S_LK_CHK:
                if (lk_bad)
                    status_next = ST_DFREE;
                else if (fmode_reg)
                    status_next = ST_OK;
                else if (keep_fits)
                begin
                    roff_next   = pay_reg;
                    rsize_next  = hd_rdata.size;
                    status_next = ST_OK;
                end
                else
                    mv_next = 1'b1;
            S_A_START:
                if (adj_reg == '0)
                    status_next = ST_NULL;
                else
                begin
                    idx_next = '0;
                    fit_next = 1'b1;
                    ret_next = S_A_RD;
                end
            S_SCAN_RD:
                if (idx_reg >= cnt_reg)
                begin
                    if (fit_reg) status_next = ST_NOSPACE;
                end
                else
                    hp_addr = idx_reg[HIDX_W-1:0];
            S_SCAN_CHK:
                if (scan_hit)
                begin
                    if (fit_reg) ah_next = hp_rdata.slot;
                end
                else
                    idx_next = idx_reg + CNT_W'(1);
            S_RM:
            begin
                cnt_next    = cnt_dec;
                hp_addr     = cnt_dec[HIDX_W-1:0];
                rm_idx_next = idx_reg[HIDX_W-1:0];
            end
            S_RM_LAST:
            begin
                ent_next = hp_rdata;
                rm_next  = 1'b1;
            end
            S_SU_RD:
                if (idx_reg == '0)
                begin
                    hp_we    = 1'b1;
                    hp_addr  = '0;
                    hp_wdata = ent_reg;
                end
                else
                    hp_addr = par_idx[HIDX_W-1:0];
            S_SU_CHK:
            begin
                hp_we = 1'b1;
                if (hp_rdata.size > ent_reg.size)
                begin
                    hp_wdata = hp_rdata;
                    idx_next = par_idx;
                end
                else
                    hp_wdata = ent_reg;
            end
            S_SD_START:
            begin
                idx_next = {1'b0, rm_idx_reg};
                hp_addr  = rm_idx_reg;
            end
            S_SD_GET:
                ent_next = hp_rdata;
            S_SD_CH:
            begin
                sel_idx_next = idx_reg;
                sel_ent_next = ent_reg;
                hp_addr      = l_idx[HIDX_W-1:0];
            end
            S_SD_L:
            begin
                if (hp_rdata.size < sel_ent_reg.size)
                begin
                    sel_idx_next = l_idx;
                    sel_ent_next = hp_rdata;
                end
                hp_addr = r_idx[HIDX_W-1:0];
            end
            S_SD_R:
                if (hp_rdata.size < sel_ent_reg.size)
                begin
                    sel_idx_next = r_idx;
                    sel_ent_next = hp_rdata;
                end
            S_SD_END:
            begin
                hp_we = 1'b1;
                if (sel_idx_reg == idx_reg)
                    hp_wdata = ent_reg;
                else
                begin
                    hp_wdata = sel_ent_reg;
                    idx_next = sel_idx_reg;
                end
            end
            S_INS:
                if (heap_full)
                    drop_next = 1'b1;
                else
                begin
                    idx_next = cnt_reg;
                    cnt_next = cnt_reg + CNT_W'(1);
                    rm_next  = 1'b0;
                end
            S_A_RD:
                hd_addr = ah_reg;
            S_A_CHK:
            begin
                c_next     = hd_rdata;
                split_next = split_ok;
                nslot_next = n_slot;
                ent_next   = '{slot: n_slot, size: s_size};
                ret_next   = S_A_OK;
                if (split_ok)
                begin
                    hd_we             = 1'b1;
                    hd_addr           = n_slot;
                    hd_wdata          = '0;
                    hd_wdata.valid    = 1'b1;
                    hd_wdata.is_free  = 1'b1;
                    hd_wdata.has_prev = 1'b1;
                    hd_wdata.prev     = ah_reg;
                    hd_wdata.has_next = hd_rdata.has_next;
                    hd_wdata.next     = hd_rdata.next;
                    hd_wdata.size     = s_size;
                end
            end
            S_A_NX_RD:
                hd_addr = c_reg.next;
            S_A_NX_WR:
            begin
                hd_we             = 1'b1;
                hd_addr           = c_reg.next;
                hd_wdata          = hd_rdata;
                hd_wdata.has_prev = 1'b1;
                hd_wdata.prev     = nslot_reg;
            end
            S_A_WC:
            begin
                hd_we            = 1'b1;
                hd_addr          = ah_reg;
                hd_wdata         = c_reg;
                hd_wdata.is_free = 1'b0;
                if (split_reg)
                begin
                    hd_wdata.has_next = 1'b1;
                    hd_wdata.next     = nslot_reg;
                    hd_wdata.size     = adj_reg[SIZE_W-1:0];
                end
            end
            S_A_OK:
            begin
                roff_next   = {ah_reg, 3'b000} + OFF_W'(HEADER_BYTES);
                rsize_next  = split_reg ? adj_reg[SIZE_W-1:0] : c_reg.size;
                status_next = ST_OK;
                moved_next  = mv_reg;
            end
            S_F_RD:
                hd_addr = bh_reg;
            S_F_B:
            begin
                b_next         = hd_rdata;
                b_next.is_free = 1'b1;
                hd_addr        = hd_rdata.next;
            end
            S_F_N:
                if (hd_rdata.is_free)
                begin
                    nb_next  = hd_rdata;
                    tgt_next = b_reg.next;
                    fit_next = 1'b0;
                    idx_next = '0;
                    ret_next = S_F_N2;
                end
            S_F_N2:
            begin
                // absorb the next block
                hd_we          = 1'b1;
                hd_addr        = b_reg.next;
                hd_wdata       = nb_reg;
                hd_wdata.valid = 1'b0;
                b_next.size     = b_reg.size + SIZE_W'(HEADER_BYTES) + nb_reg.size;
                b_next.has_next = nb_reg.has_next;
                b_next.next     = nb_reg.next;
            end
            S_F_NN_RD:
                hd_addr = b_reg.next;
            S_F_NN_WR:
            begin
                hd_we             = 1'b1;
                hd_addr           = b_reg.next;
                hd_wdata          = hd_rdata;
                hd_wdata.has_prev = 1'b1;
                hd_wdata.prev     = bh_reg;
            end
            S_F_P_CHK:
                hd_addr = b_reg.prev;
            S_F_P:
                if (hd_rdata.is_free)
                begin
                    nb_next  = hd_rdata;
                    tgt_next = b_reg.prev;
                    fit_next = 1'b0;
                    idx_next = '0;
                    ret_next = S_F_P2;
                end
            S_F_P2:
            begin
                // fold into the previous block, which becomes the one indexed
                hd_we           = 1'b1;
                hd_addr         = bh_reg;
                hd_wdata        = b_reg;
                hd_wdata.valid  = 1'b0;
                b_next          = nb_reg;
                b_next.size     = nb_reg.size + SIZE_W'(HEADER_BYTES) + b_reg.size;
                b_next.has_next = b_reg.has_next;
                b_next.next     = b_reg.next;
                bh_next         = b_reg.prev;
            end
            S_F_PN_RD:
                hd_addr = b_reg.next;
            S_F_PN_WR:
            begin
                hd_we             = 1'b1;
                hd_addr           = b_reg.next;
                hd_wdata          = hd_rdata;
                hd_wdata.has_prev = 1'b1;
                hd_wdata.prev     = bh_reg;
            end
            S_F_INS:
            begin
                hd_we    = 1'b1;
                hd_addr  = bh_reg;
                hd_wdata = b_reg;
                ent_next = '{slot: bh_reg, size: b_reg.size};
                ret_next = S_DONE;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy                 = (state_reg != S_IDLE);
        done                 = (state_reg == S_DONE);
        result.result_offset = roff_reg;
        result.granted_bytes = REQ_W'(rsize_reg);
        result.moved         = moved_reg;
        result.status        = (drop_reg && status_reg == ST_OK) ? 3'(ST_FULL)
                                                                 : 3'(status_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            ret_reg    <= S_DONE;
            clr_reg    <= '0;
            cnt_reg    <= CNT_W'(1);
            fmode_reg  <= 1'b0;
            mv_reg     <= 1'b0;
            fit_reg    <= 1'b0;
            rm_reg     <= 1'b0;
            split_reg  <= 1'b0;
            drop_reg   <= 1'b0;
            status_reg <= ST_NULL;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            clr_reg    <= clr_next;
            cnt_reg    <= cnt_next;
            fmode_reg  <= fmode_next;
            mv_reg     <= mv_next;
            fit_reg    <= fit_next;
            rm_reg     <= rm_next;
            split_reg  <= split_next;
            drop_reg   <= drop_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        adj_reg     <= adj_next;
        pay_reg     <= pay_next;
        idx_reg     <= idx_next;
        sel_idx_reg <= sel_idx_next;
        rm_idx_reg  <= rm_idx_next;
        tgt_reg     <= tgt_next;
        bh_reg      <= bh_next;
        ah_reg      <= ah_next;
        nslot_reg   <= nslot_next;
        ent_reg     <= ent_next;
        sel_ent_reg <= sel_ent_next;
        b_reg       <= b_next;
        nb_reg      <= nb_next;
        c_reg       <= c_next;
        roff_reg    <= roff_next;
        rsize_reg   <= rsize_next;
        moved_reg   <= moved_next;
    end

    `HIBA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(HEAP_DEPTH))
    `HIBA_ASSERT_IMP(a_heap_wr_live, hp_we, {1'b0, hp_addr} < cnt_reg)
    `HIBA_ASSERT_IMP(a_nospace_null, done && status_reg == ST_NOSPACE, roff_reg == '0)
    `HIBA_ASSERT_IMP(a_moved_realloc, done && moved_reg, kind_reg == K_REALLOC)
    `HIBA_ASSERT_NXT(a_done_idle, done, state_reg == S_IDLE)

endmodule
